FILE: rtl/pgsi_pkg.sv
// ----------------------------------------------------------------------------
// pgsi_pkg
// Shared widths, luma weights and the gray level threshold table for the
// grayscale / inversion pixel block.
// ----------------------------------------------------------------------------
package pgsi_pkg;

  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned PIX_W       = 3 * CHAN_W;
  localparam int unsigned SUM_W       = 22;
  localparam int unsigned GRAY_LEVELS = 1 << CHAN_W;
  localparam int unsigned BIG_W       = 320;

  localparam int unsigned R_WEIGHT = 2126;
  localparam int unsigned G_WEIGHT = 7152;
  localparam int unsigned B_WEIGHT = 722;
  localparam int unsigned SUM_MAX  = 2550000;

  localparam int unsigned LIN_MAX  = 7983;
  localparam int unsigned LIN_NUM  = 1292;
  localparam int unsigned LIN_DEN  = 1000000;

  localparam int unsigned GAM_STEP = 40;
  localparam int unsigned GAM_OFS  = 561;
  localparam int unsigned GAM_DEN  = 10761;

  typedef logic [BIG_W-1:0]                    big_t;
  typedef logic [GRAY_LEVELS-1:0][SUM_W-1:0]   thr_tab_t;

  typedef enum logic {
    MODE_GRAY   = 1'b0,
    MODE_INVERT = 1'b1
  } mode_t;

  function automatic big_t big_pow(big_t base, int unsigned n);
    big_t acc;
    acc = big_t'(1);
    for (int unsigned i = 0; i < n; i++) begin
      acc = acc * base;
    end
    return acc;
  endfunction

  // Exact test: gray level of luma sum s is at least k.
  function automatic logic gray_reaches(big_t lhs, big_t rmul, logic [SUM_W-1:0] s,
                                        int unsigned k);
    logic res;
    if (s <= SUM_W'(LIN_MAX)) begin
      res = (big_t'(s) * big_t'(LIN_NUM)) >= (big_t'(k) * big_t'(LIN_DEN));
    end else begin
      res = lhs <= (big_pow(big_t'(s), 5) * rmul);
    end
    return res;
  endfunction

  // Smallest luma sum reaching each gray level; entry 0 unused.
  function automatic thr_tab_t build_gray_thr();
    thr_tab_t         tab;
    big_t             rmul;
    big_t             smul;
    big_t             lhs;
    logic [SUM_W-1:0] lo;
    logic [SUM_W-1:0] hi;
    logic [SUM_W-1:0] mid;
    tab  = '0;
    rmul = big_pow(big_t'(GAM_DEN), 12);
    smul = big_pow(big_t'(SUM_MAX), 5);
    for (int unsigned k = 1; k < GRAY_LEVELS; k++) begin
      lhs = big_pow(big_t'(GAM_STEP * k + GAM_OFS), 12) * smul;
      lo  = '0;
      hi  = SUM_W'(SUM_MAX);
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (gray_reaches(lhs, rmul, mid, k)) begin
          hi = mid;
        end else begin
          lo = mid + SUM_W'(1);
        end
      end
      tab[k] = hi;
    end
    return tab;
  endfunction

  localparam thr_tab_t GRAY_THR = build_gray_thr();

endpackage

FILE: rtl/pixel_gray_srgb_or_invert.sv
// ----------------------------------------------------------------------------
// pixel_gray_srgb_or_invert
// Per-pixel grayscale (Rec.709 luma, sRGB gamma) or colour inversion.
// ----------------------------------------------------------------------------
// Input stream in_*: one 24-bit BGR pixel per transaction. Output stream out_*:
// one 24-bit pixel per input pixel, in order. cfg_* writes the mode bit
// (0 grayscale, 1 inversion); write it only while no pixel is in flight.
// Three register stages: input register, luma sum register, result register.
// An accepted pixel moves through these registers in that order to out_*.
// Throughput is one pixel per clock while out_tready is high; each stage is a
// single pass of short logic (constant multiplies and one add, then 255
// constant compares folded into an 8-step thermometer decode).
// Each stage loads when empty or when the stage after it moves on, so a
// stalled receiver only stops the stages behind the full ones; with out_tready
// held low the block takes up to two more pixels before in_tready drops.
// Synchronous reset empties every stage and sets grayscale mode.
// ----------------------------------------------------------------------------
module pixel_gray_srgb_or_invert (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [pgsi_pkg::PIX_W-1:0]   in_tdata,   // blue_in, green_in, red_in
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [pgsi_pkg::PIX_W-1:0]   out_tdata   // blue_out, green_out, red_out
);

  import pgsi_pkg::*;

  mode_t              mode_r;
  logic               s1_v_r;
  logic [PIX_W-1:0]   s1_pix_r;
  mode_t              s1_mode_r;
  logic               s2_v_r;
  logic [SUM_W-1:0]   s2_sum_r;
  logic [PIX_W-1:0]   s2_pix_r;
  mode_t              s2_mode_r;
  logic               out_v_r;
  logic [PIX_W-1:0]   out_pix_r;

  logic               out_ld;
  logic               s2_ld;
  logic               s1_ld;
  logic [SUM_W-1:0]   sum_nxt;
  logic [GRAY_LEVELS-1:0] thermo;
  logic [CHAN_W-1:0]  gray_nxt;
  logic [PIX_W-1:0]   out_pix_nxt;

  assign out_ld    = !out_v_r || out_tready;
  assign s2_ld     = !s2_v_r || out_ld;
  assign s1_ld     = !s1_v_r || s2_ld;
  assign in_tready = s1_ld;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pix_r;

  assign sum_nxt = SUM_W'(R_WEIGHT) * SUM_W'(s1_pix_r[2*CHAN_W +: CHAN_W])
                 + SUM_W'(G_WEIGHT) * SUM_W'(s1_pix_r[CHAN_W +: CHAN_W])
                 + SUM_W'(B_WEIGHT) * SUM_W'(s1_pix_r[0 +: CHAN_W]);

  always_comb begin
    thermo[0] = 1'b1;
    for (int k = 1; k < GRAY_LEVELS; k++) begin
      thermo[k] = s2_sum_r >= GRAY_THR[k];
    end
  end

  always_comb begin
    logic [CHAN_W-1:0] probe;
    gray_nxt = '0;
    for (int j = CHAN_W - 1; j >= 0; j--) begin
      probe = gray_nxt | (CHAN_W'(1) << j);
      if (thermo[probe]) begin
        gray_nxt = probe;
      end
    end
  end

  assign out_pix_nxt = (s2_mode_r == MODE_INVERT) ? s2_pix_r : {3{gray_nxt}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_GRAY;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= mode_t'(cfg_data);
      end
      if (s1_ld) begin
        s1_v_r <= in_tvalid;
      end
      if (s2_ld) begin
        s2_v_r <= s1_v_r;
      end
      if (out_ld) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ld && in_tvalid) begin
      s1_pix_r  <= in_tdata;
      s1_mode_r <= mode_r;
    end
    if (s2_ld && s1_v_r) begin
      s2_sum_r  <= sum_nxt;
      s2_pix_r  <= ~s1_pix_r;
      s2_mode_r <= s1_mode_r;
    end
    if (out_ld && s2_v_r) begin
      out_pix_r <= out_pix_nxt;
    end
  end

  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> s2_sum_r <= SUM_W'(SUM_MAX))
    else $error("luma sum out of range");

  a_linear_low: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s2_sum_r <= SUM_W'(LIN_MAX)) |-> gray_nxt <= CHAN_W'(10))
    else $error("linear segment gray level too high");

  a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ld && s2_v_r && s2_mode_r == MODE_GRAY) |=>
      (out_tdata[0 +: CHAN_W] == out_tdata[CHAN_W +: CHAN_W] &&
       out_tdata[0 +: CHAN_W] == out_tdata[2*CHAN_W +: CHAN_W]))
    else $error("gray pixel channels differ");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && s1_v_r) |-> s2_ld)
    else $error("input stage overwritten while full");

endmodule

FILE: tb/sv/pixel_gray_srgb_or_invert_test.sv
// ----------------------------------------------------------------------------
// pixel_gray_srgb_or_invert_test
// Stream test of the grayscale / inversion pixel block. A short table of
// directed pixels comes first: black, white, pure channels, both sides of the
// linear segment of the sRGB curve, and inversion of known patterns. About
// 1300 random pixels in several mode phases follow. Every output pixel is
// compared channel by channel with a table value or an exact integer model of
// Rec.709 luma and sRGB gamma. Both sides idle at random, the receiver also
// holds off for a long stretch, and a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module pixel_gray_srgb_or_invert_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pgsi_pkg::mode_t;
  import pgsi_pkg::MODE_GRAY;
  import pgsi_pkg::MODE_INVERT;

  localparam int unsigned RED_WEIGHT      = 2126;
  localparam int unsigned GREEN_WEIGHT    = 7152;
  localparam int unsigned BLUE_WEIGHT     = 722;
  localparam int unsigned FULL_SCALE      = 2550000;
  localparam int unsigned LINEAR_LIMIT    = 7983;
  localparam int unsigned SLOPE_NUM       = 1292;
  localparam int unsigned SLOPE_DEN       = 1000000;
  localparam int unsigned GAMMA_STEP      = 40;
  localparam int unsigned GAMMA_OFS       = 561;
  localparam int unsigned GAMMA_DEN       = 10761;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned PHASE_PIXELS    = 160;
  localparam int unsigned STIM_ROWS       = 21;

  typedef logic [319:0]               wide_t;
  typedef logic [pgsi_pkg::PIX_W-1:0] pixel_t;

  typedef struct {
    mode_t  mode;
    pixel_t pix;
    bit     fixed;
    pixel_t want;
  } stim_row_t;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   cfg_valid;
  logic   cfg_ready;
  logic   cfg_data;
  logic   in_tvalid;
  logic   in_tready;
  pixel_t in_tdata;    // blue_in, green_in, red_in
  logic   out_tvalid;
  logic   out_tready;
  pixel_t out_tdata;   // blue_out, green_out, red_out

  mode_t       mode_now;
  pixel_t      pending_pixels[$];
  int unsigned error_count;
  int unsigned quiet_cycles;
  bit          idle_on;
  bit          hold_request;

  stim_row_t stim_table[STIM_ROWS] = '{
    '{MODE_GRAY,   24'h000000, 1'b1, 24'h000000},
    '{MODE_GRAY,   24'hffffff, 1'b1, 24'hffffff},
    '{MODE_GRAY,   24'h0000ff, 1'b0, 24'h000000},
    '{MODE_GRAY,   24'h00ff00, 1'b0, 24'h000000},
    '{MODE_GRAY,   24'hff0000, 1'b0, 24'h000000},
    '{MODE_GRAY,   24'h000001, 1'b0, 24'h000000},
    '{MODE_GRAY,   24'h000100, 1'b0, 24'h000000},
    '{MODE_GRAY,   24'h00000b, 1'b0, 24'h000000},
    '{MODE_GRAY,   24'h00000c, 1'b0, 24'h000000},
    '{MODE_GRAY,   24'h010008, 1'b0, 24'h000000},
    '{MODE_GRAY,   24'h010100, 1'b0, 24'h000000},
    '{MODE_GRAY,   24'h808080, 1'b0, 24'h000000},
    '{MODE_GRAY,   24'hfefefe, 1'b0, 24'h000000},
    '{MODE_GRAY,   24'h7f7f7f, 1'b0, 24'h000000},
    '{MODE_GRAY,   24'haa55aa, 1'b0, 24'h000000},
    '{MODE_INVERT, 24'h000000, 1'b1, 24'hffffff},
    '{MODE_INVERT, 24'hffffff, 1'b1, 24'h000000},
    '{MODE_INVERT, 24'h123456, 1'b1, 24'hedcba9},
    '{MODE_INVERT, 24'ha5c30f, 1'b1, 24'h5a3cf0},
    '{MODE_INVERT, 24'h0000ff, 1'b1, 24'hffff00},
    '{MODE_GRAY,   24'h555555, 1'b0, 24'h000000}
  };

  pixel_gray_srgb_or_invert i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic wide_t raise(wide_t base, int unsigned n);
    wide_t acc;
    acc = wide_t'(1);
    repeat (n) acc = acc * base;
    return acc;
  endfunction

  // Largest level whose linear or gamma threshold lies at or below the luma sum
  function automatic logic [7:0] gray_level(int unsigned luma);
    wide_t             scaled_luma;
    wide_t             bound;
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       mid;
    longint unsigned   lin;
    if (luma <= LINEAR_LIMIT) begin
      lin = longint'(luma) * longint'(SLOPE_NUM) / longint'(SLOPE_DEN);
      return lin[7:0];
    end
    scaled_luma = raise(wide_t'(luma), 5) * raise(wide_t'(GAMMA_DEN), 12);
    lo = 0;
    hi = 255;
    while (lo < hi) begin
      mid   = (lo + hi + 1) / 2;
      bound = raise(wide_t'(GAMMA_STEP * mid + GAMMA_OFS), 12) *
              raise(wide_t'(FULL_SCALE), 5);
      if (bound <= scaled_luma) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return lo[7:0];
  endfunction

  function automatic pixel_t transform_pixel(mode_t m, pixel_t pix);
    int unsigned luma;
    logic [7:0]  gray;
    if (m == MODE_INVERT) begin
      return ~pix;
    end
    luma = RED_WEIGHT * pix[23:16] + GREEN_WEIGHT * pix[15:8] + BLUE_WEIGHT * pix[7:0];
    gray = gray_level(luma);
    return {gray, gray, gray};
  endfunction

  function automatic pixel_t random_pixel();
    int unsigned kind;
    logic [7:0]  level;
    kind  = $urandom_range(0, 9);
    level = 8'($urandom);
    case (kind)
      5, 6: begin
        return {8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                8'($urandom_range(0, 15))};
      end
      7: begin
        return {8'($urandom_range(0, 3)), 8'($urandom_range(0, 1)),
                8'($urandom_range(0, 15))};
      end
      8: begin
        return {8'($urandom_range(240, 255)), 8'($urandom_range(240, 255)),
                8'($urandom_range(240, 255))};
      end
      9: begin
        return {level, level, level};
      end
      default: begin
        return pixel_t'($urandom);
      end
    endcase
  endfunction

  // Hold valid high across back-to-back pixels; lower it only ahead of a gap
  task automatic send_pixel(input pixel_t pix, input bit fixed, input pixel_t want);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    pending_pixels.push_back(fixed ? want : transform_pixel(mode_now, pix));
  endtask

  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    mode_now = m;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic report(input string what, input logic [23:0] want, input logic [23:0] got);
    error_count++;
    $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
  endtask

  initial begin
    out_tready = 1'b0;
    hold_request = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      int unsigned stall;
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    string  chan_name[3];
    chan_name = '{"blue", "green", "red"};
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        report("unexpected pixel", 24'h0, out_tdata);
      end else begin
        want = pending_pixels.pop_front();
        for (int f = 0; f < 3; f++) begin
          if (out_tdata[8*f +: 8] !== want[8*f +: 8]) begin
            report(chan_name[f], 24'(want[8*f +: 8]), 24'(out_tdata[8*f +: 8]));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog timeout, %0d pixels outstanding", $time, pending_pixels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    error_count  = 0;
    quiet_cycles = 0;
    idle_on      = 1'b1;
    mode_now     = MODE_GRAY;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      if (stim_table[i].mode != mode_now) begin
        drain_pipeline();
        write_mode(stim_table[i].mode);
      end
      send_pixel(stim_table[i].pix, stim_table[i].fixed, stim_table[i].want);
    end

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      drain_pipeline();
      if (phase == 0) begin
        write_mode(MODE_GRAY);
      end else if (phase == 1) begin
        write_mode(MODE_INVERT);
      end else begin
        write_mode(mode_t'($urandom_range(0, 1)));
      end
      idle_on = (phase % 3 != 2);
      // stall the receiver while pixels keep arriving back to back
      if (phase == 2) begin
        hold_request = 1'b1;
      end
      repeat (PHASE_PIXELS) send_pixel(random_pixel(), 1'b0, '0);
    end

    drain_pipeline();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: pixel_gray_srgb_or_invert.f
rtl/pgsi_pkg.sv
rtl/pixel_gray_srgb_or_invert.sv
tb/sv/pixel_gray_srgb_or_invert_test.sv
